[hdl/ssns_pkg.sv]
// Shared types, constants and the segment pattern lookup for the number shifter.
package ssns_pkg;

  localparam int MAX_DIGITS_DEFAULT = 12;
  localparam int VALUE_W = 32;
  localparam int MAG_W = 31;
  localparam int PAD_W = 5;
  localparam int POINT_W = 5;
  localparam int TABLE_W = 40;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_TABLE_LOW = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TABLE_HIGH = 1'b1;

  localparam logic [7:0] POINT_BIT = 8'h01;
  localparam logic [7:0] BLANK_BYTE = 8'h00;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [PAD_W-1:0] pad;
    logic [POINT_W-1:0] point;
  } entry_t;

  function automatic logic [7:0] pattern_for(input logic [TABLE_W-1:0] table_low,
                                             input logic [TABLE_W-1:0] table_high,
                                             input logic [3:0] digit);
    logic [7:0] pattern;
    unique case (digit)
      4'd0: pattern = table_low[7:0];
      4'd1: pattern = table_low[15:8];
      4'd2: pattern = table_low[23:16];
      4'd3: pattern = table_low[31:24];
      4'd4: pattern = table_low[39:32];
      4'd5: pattern = table_high[7:0];
      4'd6: pattern = table_high[15:8];
      4'd7: pattern = table_high[23:16];
      4'd8: pattern = table_high[31:24];
      4'd9: pattern = table_high[39:32];
      default: pattern = BLANK_BYTE;
    endcase
    return pattern;
  endfunction

endpackage

[hdl/ssns_front.sv]
// Input stage: accepts beats, clamps negative values and saturates the pad width.
module ssns_front #(
  parameter int MAX_DIGITS = ssns_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ssns_pkg::VALUE_W-1:0] value,
  input  logic [3:0]                          pad_width,
  input  logic signed [ssns_pkg::POINT_W-1:0] point_position,
  output logic                                push_valid,
  input  logic                                push_ready,
  output ssns_pkg::entry_t                    push_entry
);
  import ssns_pkg::*;

  logic   held;
  entry_t entry;
  entry_t entry_next;

  assign in_ready = !held || push_ready;
  assign push_valid = held;
  assign push_entry = entry;

  always_comb begin
    entry_next.magnitude = value[VALUE_W-1] ? '0 : value[MAG_W-1:0];
    if ({1'b0, pad_width} > PAD_W'(MAX_DIGITS)) begin
      entry_next.pad = PAD_W'(MAX_DIGITS);
    end else begin
      entry_next.pad = {1'b0, pad_width};
    end
    entry_next.point = point_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
    if (in_valid && in_ready) begin
      entry <= entry_next;
    end
  end

endmodule

[hdl/ssns_queue.sv]
// Two-entry queue between the input stage and the digit emitter.
module ssns_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  ssns_pkg::entry_t push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output ssns_pkg::entry_t pop_entry
);
  import ssns_pkg::*;

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_entry = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

[hdl/ssns_back.sv]
// Digit emitter: one decimal digit per unstalled cycle, driving the result register.
module ssns_back #(
  parameter int MAX_DIGITS = ssns_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  ssns_pkg::entry_t                    pop_entry,
  input  logic [ssns_pkg::TABLE_W-1:0]        table_low,
  input  logic [ssns_pkg::TABLE_W-1:0]        table_high,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          segment_byte,
  output logic                                is_last,
  output logic                                no_byte
);
  import ssns_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic               busy;
  logic [MAG_W-1:0]   magnitude;
  logic [CW-1:0]      k;
  logic [CW-1:0]      pad;
  logic [POINT_W-1:0] point;

  logic [62:0]        product;
  logic [27:0]        quotient;
  logic [MAG_W-1:0]   quotient_x10;
  logic [3:0]         digit;
  logic [CW:0]        k_plus;
  logic               have_digit;
  logic               pad_done;
  logic               step;
  logic [7:0]         byte_next;
  logic               last_next;
  logic               none_next;

  assign pop_ready = !busy;
  assign step = busy && (!out_valid || out_ready);

  assign product = 63'(magnitude) * 63'(32'hCCCC_CCCD);
  assign quotient = product[62:35];
  assign quotient_x10 = MAG_W'({quotient, 3'b000}) + MAG_W'({quotient, 1'b0});
  assign digit = 4'(magnitude - quotient_x10);
  assign k_plus = {1'b0, k} + (CW + 1)'(1);
  assign have_digit = (magnitude != '0) && ({1'b0, k} < (CW + 1)'(MAX_DIGITS));
  assign pad_done = (k_plus >= {1'b0, pad});

  always_comb begin
    byte_next = BLANK_BYTE;
    none_next = 1'b0;
    last_next = pad_done;
    if (have_digit) begin
      byte_next = pattern_for(table_low, table_high, digit);
      if (point == POINT_W'(k)) begin
        byte_next = byte_next | POINT_BIT;
      end
      last_next = pad_done && ((quotient == '0) || (k_plus == (CW + 1)'(MAX_DIGITS)));
    end else if ((k == '0) && (pad == '0)) begin
      none_next = 1'b1;
      last_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!busy) begin
        busy <= pop_valid;
      end else if (step && last_next) begin
        busy <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (!busy) begin
      magnitude <= pop_entry.magnitude;
      pad <= CW'(pop_entry.pad);
      point <= pop_entry.point;
      k <= '0;
    end else if (step) begin
      if (have_digit) begin
        magnitude <= MAG_W'(quotient);
      end
      k <= k_plus[CW-1:0];
    end
    if (step) begin
      segment_byte <= byte_next;
      is_last <= last_next;
      no_byte <= none_next;
    end
  end

endmodule

[hdl/seven_segment_number_shifter.sv]
// Top level of the seven-segment number shifter.
// Input channel (in_valid/in_ready) takes one beat per number: value, pad_width
// and point_position. Output channel (out_valid/out_ready) gives one beat per
// segment byte, least significant digit first, then blank bytes up to the pad
// width; is_last marks the final beat of a number. A number with no digits and
// no padding gives a single beat with no_byte and is_last set.
// The segment table is written through cfg_write, cfg_index and cfg_data and
// must only change while no number is in flight.
// A number passes the input register, the queue and the emitter load in order.
// The digit emitter gives one beat per cycle unless the output stalls, one
// decimal digit per step through a reciprocal multiply. It loads each number
// in a step of its own and takes the next only after that number's last beat.
// The input stage and a two-entry queue keep taking numbers while the emitter
// is busy. When the receiver stalls, the emitter holds its result register and
// stops; once the queue and the input stage are full, in_ready drops.
// Reset clears all handshake state and both segment table registers to zero.
module seven_segment_number_shifter #(
  parameter int MAX_DIGITS = ssns_pkg::MAX_DIGITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ssns_pkg::VALUE_W-1:0] value,
  input  logic [3:0]                          pad_width,
  input  logic signed [ssns_pkg::POINT_W-1:0] point_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          segment_byte,
  output logic                                is_last,
  output logic                                no_byte,
  input  logic                                cfg_write,
  input  logic [ssns_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ssns_pkg::TABLE_W-1:0]        cfg_data
);
  import ssns_pkg::*;

  logic               push_valid;
  logic               push_ready;
  entry_t             push_entry;
  logic               pop_valid;
  logic               pop_ready;
  entry_t             pop_entry;
  logic [TABLE_W-1:0] table_low;
  logic [TABLE_W-1:0] table_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_low <= '0;
      table_high <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TABLE_LOW:  table_low <= cfg_data;
        REG_TABLE_HIGH: table_high <= cfg_data;
        default: ;
      endcase
    end
  end

  ssns_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .pad_width(pad_width),
    .point_position(point_position),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_entry(push_entry)
  );

  ssns_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_entry(push_entry),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_entry(pop_entry)
  );

  ssns_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_entry(pop_entry),
    .table_low(table_low),
    .table_high(table_high),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .segment_byte(segment_byte),
    .is_last(is_last),
    .no_byte(no_byte)
  );

endmodule

[tb/tb_seven_segment_number_shifter.sv]
// Self-checking testbench for the seven-segment number shifter, with a byte scoreboard.
`timescale 1ns / 100ps

typedef struct packed {
  logic [7:0] segment;
  logic       last;
  logic       latch_only;
} shift_beat_t;

class segment_scoreboard;
  localparam int DIGIT_LIMIT = ssns_pkg::MAX_DIGITS_DEFAULT;

  logic [ssns_pkg::TABLE_W-1:0] table_low;
  logic [ssns_pkg::TABLE_W-1:0] table_high;
  shift_beat_t expected_beats[$];
  int errors;

  function new();
    table_low = '0;
    table_high = '0;
    errors = 0;
  endfunction

  function void load_table(input logic [ssns_pkg::CFG_INDEX_W-1:0] index,
                           input logic [ssns_pkg::TABLE_W-1:0] data);
    if (index == ssns_pkg::REG_TABLE_LOW) table_low = data;
    else table_high = data;
  endfunction

  function logic [7:0] digit_pattern(input logic [3:0] digit);
    if (digit < 4'd5) return table_low[8*digit +: 8];
    return table_high[8*(digit-4'd5) +: 8];
  endfunction

  function void queue_number_bytes(input logic signed [31:0] number,
                                   input logic [3:0] pad,
                                   input logic signed [4:0] point);
    logic [30:0] magnitude;
    logic [3:0] digit_list[DIGIT_LIMIT];
    int len;
    int pad_len;
    int total;
    shift_beat_t beat;
    magnitude = number[31] ? '0 : number[30:0];
    len = 0;
    while (magnitude != 0 && len < DIGIT_LIMIT) begin
      digit_list[len] = 4'(magnitude % 10);
      magnitude = magnitude / 10;
      len++;
    end
    pad_len = (int'(pad) > DIGIT_LIMIT) ? DIGIT_LIMIT : int'(pad);
    total = (len > pad_len) ? len : pad_len;
    if (total == 0) begin
      beat.segment = ssns_pkg::BLANK_BYTE;
      beat.last = 1'b1;
      beat.latch_only = 1'b1;
      expected_beats.push_back(beat);
      return;
    end
    for (int k = 0; k < total; k++) begin
      beat.segment = ssns_pkg::BLANK_BYTE;
      if (k < len) begin
        beat.segment = digit_pattern(digit_list[k]);
        if (!point[4] && int'(point[3:0]) == k) beat.segment |= ssns_pkg::POINT_BIT;
      end
      beat.last = (k + 1 == total);
      beat.latch_only = 1'b0;
      expected_beats.push_back(beat);
    end
  endfunction

  function void check_beat(input logic [7:0] segment, input logic last,
                           input logic latch_only);
    shift_beat_t want;
    if (expected_beats.size() == 0) begin
      $error("unexpected output beat: segment_byte %02h is_last %0b no_byte %0b",
             segment, last, latch_only);
      errors++;
      return;
    end
    want = expected_beats.pop_front();
    if (segment !== want.segment) begin
      $error("segment_byte: expected %02h, actual %02h", want.segment, segment);
      errors++;
    end
    if (last !== want.last) begin
      $error("is_last: expected %0b, actual %0b", want.last, last);
      errors++;
    end
    if (latch_only !== want.latch_only) begin
      $error("no_byte: expected %0b, actual %0b", want.latch_only, latch_only);
      errors++;
    end
  endfunction

  function void check_drained();
    if (expected_beats.size() != 0) begin
      $error("%0d expected output beats never arrived", expected_beats.size());
      errors++;
    end
  endfunction
endclass

module tb_seven_segment_number_shifter;
  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [ssns_pkg::VALUE_W-1:0] value;
  logic [3:0]                          pad_width;
  logic signed [ssns_pkg::POINT_W-1:0] point_position;
  logic                                out_valid;
  logic                                out_ready;
  logic [7:0]                          segment_byte;
  logic                                is_last;
  logic                                no_byte;
  logic                                cfg_write;
  logic [ssns_pkg::CFG_INDEX_W-1:0]    cfg_index;
  logic [ssns_pkg::TABLE_W-1:0]        cfg_data;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;

  segment_scoreboard board = new();

  seven_segment_number_shifter DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .pad_width(pad_width),
    .point_position(point_position),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .segment_byte(segment_byte),
    .is_last(is_last),
    .no_byte(no_byte),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_number(input logic signed [31:0] number, input logic [3:0] pad,
                             input logic signed [4:0] point);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= number;
    pad_width <= pad;
    point_position <= point;
    do @(posedge clk); while (!in_ready);
    board.queue_number_bytes(number, pad, point);
  endtask

  task automatic wait_all_shifted();
    in_valid <= 1'b0;
    while (board.expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_tables(input logic [ssns_pkg::TABLE_W-1:0] low_patterns,
                              input logic [ssns_pkg::TABLE_W-1:0] high_patterns);
    cfg_write <= 1'b1;
    cfg_index <= ssns_pkg::REG_TABLE_LOW;
    cfg_data <= low_patterns;
    @(posedge clk);
    board.load_table(ssns_pkg::REG_TABLE_LOW, low_patterns);
    cfg_index <= ssns_pkg::REG_TABLE_HIGH;
    cfg_data <= high_patterns;
    @(posedge clk);
    board.load_table(ssns_pkg::REG_TABLE_HIGH, high_patterns);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [ssns_pkg::TABLE_W-1:0] random_table();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[ssns_pkg::TABLE_W-1:0];
  endfunction

  function automatic logic [31:0] random_number();
    logic [31:0] bits;
    bits = $urandom;
    case ($urandom_range(0, 5))
      0: return bits;
      1: return $urandom_range(0, 9);
      2: return $urandom_range(0, 999999);
      3: return {1'b0, bits[30:0]};
      4: return {1'b1, bits[30:0]};
      default: return $urandom_range(1000000, 32'h7FFFFFFF);
    endcase
  endfunction

  function automatic logic [3:0] random_pad();
    if ($urandom_range(0, 3) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, 12));
  endfunction

  function automatic logic [4:0] random_point();
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
    return 5'($signed($urandom_range(0, 12)) - 1);
  endfunction

  task automatic send_random_numbers(input int count);
    repeat (count) send_number(random_number(), random_pad(), random_point());
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    value <= '0;
    pad_width <= '0;
    point_position <= '0;
    cfg_write <= 1'b0;
    cfg_index <= ssns_pkg::REG_TABLE_LOW;
    cfg_data <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_number(32'sd0, 4'd0, -5'sd1);
    send_number(32'sd1234, 4'd2, 5'sd1);
    wait_all_shifted();
    write_tables({8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC}, {8'hF6, 8'hFE, 8'hE0, 8'hBE, 8'hB6});

    send_number(32'sd0, 4'd0, -5'sd1);
    send_number(32'sd0, 4'd5, 5'sd0);
    send_number(-32'sd1, 4'd0, 5'sd0);
    send_number(32'h80000000, 4'd12, 5'sd3);
    send_number(32'h80000000, 4'd0, -5'sd1);
    send_number(32'h7FFFFFFF, 4'd0, 5'sd0);
    send_number(32'h7FFFFFFF, 4'd0, 5'sd9);
    send_number(32'sd1, 4'd15, 5'sd0);
    send_number(32'sd1234567890, 4'd12, 5'sd15);
    send_number(32'sd9, 4'd0, 5'sd1);
    send_number(32'sd100, 4'd3, 5'sd2);
    send_number(32'sd5, 4'd0, -5'sd16);
    send_number(32'sd999999999, 4'd11, 5'sd8);
    send_number(32'sd10, 4'd1, 5'sd1);
    send_number(32'sd7, 4'd13, 5'sd12);
    send_number(32'sd1286608622, 4'd10, 5'sd4);
    send_number(32'sd1023456789, 4'd9, 5'sd10);
    send_number(32'sd42, 4'd8, -5'sd2);
    wait_all_shifted();

    write_tables('1, '1);
    send_random_numbers(20);
    wait_all_shifted();

    write_tables(random_table(), random_table());
    send_idle_pct = 87;
    send_random_numbers(60);
    wait_all_shifted();

    write_tables(random_table(), random_table());
    send_idle_pct = 0;
    recv_stall_pct = 87;
    send_random_numbers(60);
    wait_all_shifted();

    write_tables('0, random_table());
    send_idle_pct = 25;
    recv_stall_pct = 25;
    send_random_numbers(60);
    wait_all_shifted();

    write_tables(random_table(), random_table());
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 400;
    send_random_numbers(40);
    wait_all_shifted();

    repeat (20) @(posedge clk);
    board.check_drained();
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
      @(posedge clk);
      if (out_valid && out_ready) board.check_beat(segment_byte, is_last, no_byte);
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

[seven_segment_number_shifter.f]
hdl/ssns_pkg.sv
hdl/ssns_front.sv
hdl/ssns_queue.sv
hdl/ssns_back.sv
hdl/seven_segment_number_shifter.sv
tb/tb_seven_segment_number_shifter.sv
